// ----- rtl/bse_pkg.sv -----
// ----------------------------------------------------------------------------
// bse_pkg
// Shared constants, types and helpers of the byte string entropy estimator.
// ----------------------------------------------------------------------------
package bse_pkg;

    localparam int MAX_LEN    = 256;
    localparam int FRAC_BITS  = 16;

    localparam int BIN_W      = 8;
    localparam int NUM_BINS   = 2 ** BIN_W;
    localparam int CNT_W      = $clog2(MAX_LEN + 1);
    localparam int K_W        = $clog2(CNT_W);
    localparam int LOG_W      = K_W + FRAC_BITS;
    localparam int SUM_W      = CNT_W + LOG_W;
    localparam int ACC_W      = (SUM_W + 1 > 13) ? SUM_W + 1 : 13;
    localparam int ITER_W     = $clog2(FRAC_BITS);
    localparam int MANT_FRAC  = 31;
    localparam int MANT_W     = MANT_FRAC + 1;
    localparam int SHIFT_W    = $clog2(MANT_W);

    localparam int OUT_W      = 12;
    localparam int OUT_MAX    = 4095;
    localparam int THR_W      = 12;
    localparam int THR_RESET  = 80;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UPD,
        ST_NSTART,
        ST_NWAIT,
        ST_RD,
        ST_CHK,
        ST_BWAIT,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] x;
    } log_req_t;

    typedef struct packed {
        logic             done;
        logic [LOG_W-1:0] result;
    } log_rsp_t;

    function automatic logic [K_W-1:0] msb_index(input logic [CNT_W-1:0] x);
        logic [K_W-1:0] k;
        k = '0;
        for (int i = 0; i < CNT_W; i++) begin
            if (x[i]) begin
                k = K_W'(i);
            end
        end
        return k;
    endfunction

endpackage

// ----- rtl/bse_log2.sv -----
// ----------------------------------------------------------------------------
// bse_log2
// Iterative fixed-point log2: integer part from the top set bit, one
// fraction bit per cycle by squaring the mantissa.
// ----------------------------------------------------------------------------
module bse_log2 (
    input  logic              aclk,
    input  logic              aresetn,
    input  bse_pkg::log_req_t req,
    output bse_pkg::log_rsp_t rsp
);

    logic                             run_reg;
    logic                             done_reg;
    logic [bse_pkg::ITER_W-1:0]       iter_reg;
    logic [bse_pkg::MANT_W-1:0]       m_reg;
    logic [bse_pkg::MANT_W-1:0]       m_next;
    logic [bse_pkg::K_W-1:0]          k_reg;
    logic [bse_pkg::FRAC_BITS-1:0]    frac_reg;
    logic [bse_pkg::K_W-1:0]          k_start;
    logic [bse_pkg::SHIFT_W-1:0]      shift_amt;
    logic [2*bse_pkg::MANT_W-1:0]     square;
    logic [bse_pkg::MANT_W:0]         square_sh;
    logic                             bit_next;

    assign k_start   = bse_pkg::msb_index(req.x);
    assign shift_amt = bse_pkg::SHIFT_W'(bse_pkg::MANT_FRAC) - bse_pkg::SHIFT_W'(k_start);
    assign square    = 64'(m_reg) * 64'(m_reg);
    assign square_sh = square[2*bse_pkg::MANT_W-1:bse_pkg::MANT_FRAC];
    assign bit_next  = square_sh[bse_pkg::MANT_W];
    assign m_next    = bit_next ? square_sh[bse_pkg::MANT_W:1]
                                : square_sh[bse_pkg::MANT_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                run_reg <= 1'b1;
            end else if (run_reg &&
                         iter_reg == bse_pkg::ITER_W'(bse_pkg::FRAC_BITS - 1)) begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            iter_reg <= '0;
            k_reg    <= k_start;
            m_reg    <= bse_pkg::MANT_W'(req.x) << shift_amt;
            frac_reg <= '0;
        end else if (run_reg) begin
            iter_reg <= iter_reg + 1'b1;
            m_reg    <= m_next;
            frac_reg <= {frac_reg[bse_pkg::FRAC_BITS-2:0], bit_next};
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = {k_reg, frac_reg};

endmodule

// ----- rtl/byte_string_entropy_estimate.sv -----
// ----------------------------------------------------------------------------
// byte_string_entropy_estimate
// Per-string byte histogram in a 256-bin memory, length-scaled Shannon
// entropy in whole bits on the final byte, with low entropy and overflow flags.
// Each byte takes a histogram read, then a write-back; no new byte is taken
// until the write-back is done. Final byte: log2 of the length, then a walk
// over all bins that takes the log2 of each count above one and sums it in.
// Reset clears the histogram valid bits at once; no clearing pass.
// The result waits in an output register while the next string is taken.
// ----------------------------------------------------------------------------
module byte_string_entropy_estimate (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [7:0]                 s_symbol_byte,
    input  logic                       s_last_byte,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [bse_pkg::OUT_W-1:0]  m_entropy_bits,
    output logic                       m_low_entropy,
    output logic                       m_length_overflow,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [bse_pkg::THR_W-1:0]  cfg_threshold_bits
);

    bse_pkg::state_t state_reg;
    bse_pkg::state_t state_next;

    logic [bse_pkg::CNT_W-1:0] mem [bse_pkg::NUM_BINS];
    logic [bse_pkg::CNT_W-1:0] mem_rdata_reg;
    logic [bse_pkg::NUM_BINS-1:0] bin_valid_reg;
    logic                       mem_rd_en;
    logic [bse_pkg::BIN_W-1:0]  mem_rd_addr;
    logic                       mem_we;

    logic [bse_pkg::BIN_W-1:0]  sym_reg;
    logic                       last_reg;
    logic [bse_pkg::CNT_W-1:0]  byte_count_reg;
    logic                       overflow_reg;
    logic [bse_pkg::BIN_W-1:0]  walk_addr_reg;
    logic [bse_pkg::CNT_W-1:0]  cur_cnt_reg;
    logic [bse_pkg::SUM_W-1:0]  total_reg;
    logic [bse_pkg::SUM_W-1:0]  sum_reg;
    logic [bse_pkg::THR_W-1:0]  threshold_reg;

    logic                       m_valid_reg;
    logic [bse_pkg::OUT_W-1:0]  m_entropy_bits_reg;
    logic                       m_low_entropy_reg;
    logic                       m_length_overflow_reg;

    bse_pkg::log_req_t          log_req;
    bse_pkg::log_rsp_t          log_rsp;

    logic [bse_pkg::CNT_W-1:0]  upd_old;
    logic [bse_pkg::CNT_W-1:0]  chk_cnt;
    logic                       under_max;
    logic                       walk_last;
    logic                       fin_fire;
    logic [bse_pkg::ACC_W-1:0]  diff;
    logic [bse_pkg::ACC_W-1:0]  diff_sh;
    logic [bse_pkg::OUT_W-1:0]  ent;

    bse_log2 u_log2 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (log_req),
        .rsp     (log_rsp)
    );

    assign upd_old   = bin_valid_reg[sym_reg] ? mem_rdata_reg : '0;
    assign chk_cnt   = bin_valid_reg[walk_addr_reg] ? mem_rdata_reg : '0;
    assign under_max = byte_count_reg < bse_pkg::CNT_W'(bse_pkg::MAX_LEN);
    assign walk_last = walk_addr_reg == bse_pkg::BIN_W'(bse_pkg::NUM_BINS - 1);
    assign fin_fire  = (state_reg == bse_pkg::ST_FIN) && (!m_valid_reg || m_ready);

    assign diff    = (sum_reg >= total_reg) ? '0
                   : bse_pkg::ACC_W'(total_reg) - bse_pkg::ACC_W'(sum_reg);
    assign diff_sh = diff >> bse_pkg::FRAC_BITS;
    assign ent     = (diff_sh > bse_pkg::ACC_W'(bse_pkg::OUT_MAX))
                   ? bse_pkg::OUT_W'(bse_pkg::OUT_MAX) : diff_sh[bse_pkg::OUT_W-1:0];

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bse_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = bse_pkg::ST_UPD;
                end
            end
            bse_pkg::ST_UPD: begin
                state_next = last_reg ? bse_pkg::ST_NSTART : bse_pkg::ST_IDLE;
            end
            bse_pkg::ST_NSTART: begin
                state_next = bse_pkg::ST_NWAIT;
            end
            bse_pkg::ST_NWAIT: begin
                if (log_rsp.done) begin
                    state_next = bse_pkg::ST_RD;
                end
            end
            bse_pkg::ST_RD: begin
                state_next = bse_pkg::ST_CHK;
            end
            bse_pkg::ST_CHK: begin
                if (chk_cnt > bse_pkg::CNT_W'(1)) begin
                    state_next = bse_pkg::ST_BWAIT;
                end else begin
                    state_next = walk_last ? bse_pkg::ST_FIN : bse_pkg::ST_RD;
                end
            end
            bse_pkg::ST_BWAIT: begin
                if (log_rsp.done) begin
                    state_next = walk_last ? bse_pkg::ST_FIN : bse_pkg::ST_RD;
                end
            end
            bse_pkg::ST_FIN: begin
                if (fin_fire) begin
                    state_next = bse_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bse_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready     = 1'b0;
        mem_rd_en   = 1'b0;
        mem_rd_addr = walk_addr_reg;
        mem_we      = 1'b0;
        log_req     = '0;
        case (state_reg)
            bse_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                mem_rd_en   = s_valid;
                mem_rd_addr = s_symbol_byte;
            end
            bse_pkg::ST_UPD: begin
                mem_we = under_max;
            end
            bse_pkg::ST_NSTART: begin
                log_req.start = 1'b1;
                log_req.x     = byte_count_reg;
            end
            bse_pkg::ST_RD: begin
                mem_rd_en = 1'b1;
            end
            bse_pkg::ST_CHK: begin
                log_req.start = chk_cnt > bse_pkg::CNT_W'(1);
                log_req.x     = chk_cnt;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_rd_en) begin
            mem_rdata_reg <= mem[mem_rd_addr];
        end
        if (mem_we) begin
            mem[sym_reg] <= upd_old + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= bse_pkg::ST_IDLE;
            bin_valid_reg  <= '0;
            byte_count_reg <= '0;
            overflow_reg   <= 1'b0;
            threshold_reg  <= bse_pkg::THR_W'(bse_pkg::THR_RESET);
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                threshold_reg <= cfg_threshold_bits;
            end
            if (state_reg == bse_pkg::ST_UPD) begin
                if (under_max) begin
                    bin_valid_reg[sym_reg] <= 1'b1;
                    byte_count_reg         <= byte_count_reg + 1'b1;
                end else begin
                    overflow_reg <= 1'b1;
                end
            end
            if (fin_fire) begin
                bin_valid_reg  <= '0;
                byte_count_reg <= '0;
                overflow_reg   <= 1'b0;
                m_valid_reg    <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == bse_pkg::ST_IDLE && s_valid) begin
            sym_reg  <= s_symbol_byte;
            last_reg <= s_last_byte;
        end
        if (state_reg == bse_pkg::ST_NWAIT && log_rsp.done) begin
            total_reg     <= bse_pkg::SUM_W'(byte_count_reg) * bse_pkg::SUM_W'(log_rsp.result);
            sum_reg       <= '0;
            walk_addr_reg <= '0;
        end
        if (state_reg == bse_pkg::ST_CHK) begin
            cur_cnt_reg <= chk_cnt;
            if (!(chk_cnt > bse_pkg::CNT_W'(1))) begin
                walk_addr_reg <= walk_addr_reg + 1'b1;
            end
        end
        if (state_reg == bse_pkg::ST_BWAIT && log_rsp.done) begin
            sum_reg       <= sum_reg
                           + bse_pkg::SUM_W'(cur_cnt_reg) * bse_pkg::SUM_W'(log_rsp.result);
            walk_addr_reg <= walk_addr_reg + 1'b1;
        end
        if (fin_fire) begin
            m_entropy_bits_reg    <= ent;
            m_low_entropy_reg     <= ent < threshold_reg;
            m_length_overflow_reg <= overflow_reg;
        end
    end

    assign cfg_ready         = 1'b1;
    assign m_valid           = m_valid_reg;
    assign m_entropy_bits    = m_entropy_bits_reg;
    assign m_low_entropy     = m_low_entropy_reg;
    assign m_length_overflow = m_length_overflow_reg;

endmodule

// ----- tb/tb_byte_string_entropy_estimate.sv -----
// ----------------------------------------------------------------------------
// tb_byte_string_entropy_estimate
// Self-checking bench for the byte string entropy estimator. Strings are fed
// one byte per transaction; an in-bench histogram and fixed-point log2 predict
// each result, which is matched in order against the result channel. A short
// table of directed strings comes first, then random strings over several
// threshold settings, with random idling on both channels and one long
// receiver hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_byte_string_entropy_estimate;

    localparam int LIMIT       = 4000000;
    localparam int DRAIN       = 64;
    localparam int HOLD_CYCLES = 3000;
    localparam int PHASES      = 5;
    localparam int PHASE_ITEMS = 55;

    typedef struct {
        logic [bse_pkg::OUT_W-1:0] bits;
        logic                      low;
        logic                      ovf;
    } score_t;

    typedef struct {
        logic [7:0]                sym;
        logic                      last;
        bit                        typed;
        logic [bse_pkg::OUT_W-1:0] bits;
        logic                      low;
        logic                      ovf;
    } byte_row_t;

    logic                        aclk               = 1'b0;
    logic                        aresetn            = 1'b0;
    logic                        s_valid            = 1'b0;
    logic                        s_ready;
    logic [7:0]                  s_symbol_byte      = '0;
    logic                        s_last_byte        = 1'b0;
    logic                        m_valid;
    logic                        m_ready            = 1'b0;
    logic [bse_pkg::OUT_W-1:0]   m_entropy_bits;
    logic                        m_low_entropy;
    logic                        m_length_overflow;
    logic                        cfg_valid          = 1'b0;
    logic                        cfg_ready;
    logic [bse_pkg::THR_W-1:0]   cfg_threshold_bits = '0;

    score_t                      expected_scores[$];
    int unsigned                 hist[bse_pkg::NUM_BINS];
    int unsigned                 hist_len  = 0;
    bit                          hist_over = 1'b0;
    logic [bse_pkg::THR_W-1:0]   thr_model = bse_pkg::THR_W'(bse_pkg::THR_RESET);

    int                  errors       = 0;
    int                  results_seen = 0;
    int                  cycles       = 0;
    int                  items_sent   = 0;
    int                  stall_left   = 0;
    bit                  hold_done    = 1'b0;
    bit                  calm         = 1'b0;

    byte_string_entropy_estimate DUT (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_symbol_byte      (s_symbol_byte),
        .s_last_byte        (s_last_byte),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_entropy_bits     (m_entropy_bits),
        .m_low_entropy      (m_low_entropy),
        .m_length_overflow  (m_length_overflow),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_threshold_bits (cfg_threshold_bits)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic void log_fault(input string msg);
        errors++;
        if (errors <= 10) begin
            $display("%s", msg);
        end
    endfunction

    function automatic logic [63:0] log2_fixed(input int unsigned x);
        int unsigned k;
        logic [63:0] m;
        logic [63:0] frac;
        if (x == 0) begin
            return 64'd0;
        end
        k = 0;
        while (k < 31 && (x >> (k + 1)) != 0) begin
            k++;
        end
        m = 64'(x) << (bse_pkg::MANT_FRAC - k);
        frac = '0;
        for (int i = 0; i < bse_pkg::FRAC_BITS; i++) begin
            m = (m * m) >> bse_pkg::MANT_FRAC;
            frac = frac << 1;
            if (m >= (64'd1 << (bse_pkg::MANT_FRAC + 1))) begin
                frac = frac | 64'd1;
                m = m >> 1;
            end
        end
        return (64'(k) << bse_pkg::FRAC_BITS) | frac;
    endfunction

    function automatic logic [bse_pkg::OUT_W-1:0] string_entropy();
        logic [63:0] total;
        logic [63:0] sum;
        logic [63:0] diff;
        if (hist_len == 0) begin
            return '0;
        end
        total = 64'(hist_len) * log2_fixed(hist_len);
        sum = '0;
        for (int i = 0; i < bse_pkg::NUM_BINS; i++) begin
            if (hist[i] != 0) begin
                sum += 64'(hist[i]) * log2_fixed(hist[i]);
            end
        end
        if (sum >= total) begin
            return '0;
        end
        diff = (total - sum) >> bse_pkg::FRAC_BITS;
        if (diff > 64'(bse_pkg::OUT_MAX)) begin
            diff = 64'(bse_pkg::OUT_MAX);
        end
        return bse_pkg::OUT_W'(diff);
    endfunction

    function automatic bit absorb_byte(input logic [7:0] b, input logic l,
                                       output score_t s);
        s = '{default: '0};
        if (hist_len < bse_pkg::MAX_LEN) begin
            hist[b]++;
            hist_len++;
        end else begin
            hist_over = 1'b1;
        end
        if (!l) begin
            return 1'b0;
        end
        s.bits = string_entropy();
        s.low  = (s.bits < thr_model);
        s.ovf  = hist_over;
        foreach (hist[i]) begin
            hist[i] = 0;
        end
        hist_len  = 0;
        hist_over = 1'b0;
        return 1'b1;
    endfunction

    function automatic bit sender_pause();
        return !calm && ($urandom_range(0, 99) < 24);
    endfunction

    // called right after a rising edge; returns right after the accepting edge
    task automatic offer(input logic [7:0] b, input logic l, input bit typed,
                         input score_t typed_s);
        score_t s;
        while (sender_pause()) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_symbol_byte <= b;
        s_last_byte   <= l;
        do @(posedge aclk); while (!(s_valid && s_ready));
        items_sent++;
        if (absorb_byte(b, l, s)) begin
            expected_scores.push_back(typed ? typed_s : s);
        end
    endtask

    task automatic send_string(input int len, input logic [7:0] mask);
        logic [7:0] base;
        score_t blank;
        blank = '{default: '0};
        base  = 8'($urandom);
        for (int i = 0; i < len; i++) begin
            offer(base ^ (8'($urandom) & mask), (i == len - 1), 1'b0, blank);
        end
    endtask

    task automatic send_random_string();
        logic [7:0] masks[5];
        masks = '{8'h00, 8'h01, 8'h03, 8'h0F, 8'hFF};
        send_string($urandom_range(1, 12), masks[$urandom_range(0, 4)]);
    endtask

    // drop valid, wait for every result, then give the block time to go idle
    task automatic settle();
        s_valid <= 1'b0;
        while (expected_scores.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN) @(posedge aclk);
    endtask

    task automatic set_threshold(input logic [bse_pkg::THR_W-1:0] v);
        cfg_valid          <= 1'b1;
        cfg_threshold_bits <= v;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        thr_model = v;
        @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!hold_done && results_seen >= 20) begin
            hold_done  <= 1'b1;
            stall_left <= HOLD_CYCLES;
            m_ready    <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(0, 99) >= 24);
        end
    end

    always @(posedge aclk) begin
        score_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_scores.size() == 0) begin
                log_fault($sformatf("unexpected result: bits=%0d low=%0b ovf=%0b",
                                    m_entropy_bits, m_low_entropy, m_length_overflow));
            end else begin
                e = expected_scores.pop_front();
                if (m_entropy_bits !== e.bits || m_low_entropy !== e.low
                        || m_length_overflow !== e.ovf) begin
                    log_fault($sformatf({"result %0d mismatch: expected bits=%0d low=%0b ",
                                         "ovf=%0b, got bits=%0d low=%0b ovf=%0b"},
                                        results_seen, e.bits, e.low, e.ovf,
                                        m_entropy_bits, m_low_entropy, m_length_overflow));
                end
            end
            results_seen <= results_seen + 1;
        end
    end

    initial begin
        byte_row_t   rows[$];
        score_t      typed_s;
        int unsigned perm[bse_pkg::NUM_BINS];
        int unsigned j;
        int unsigned tmp;
        int          phase_start;
        logic [bse_pkg::THR_W-1:0] thr;

        foreach (hist[i]) begin
            hist[i] = 0;
        end

        // threshold is at its reset value for the whole table
        rows = '{
            '{8'h00, 1'b1, 1'b1, 12'd0, 1'b1, 1'b0},
            '{8'hFF, 1'b1, 1'b1, 12'd0, 1'b1, 1'b0},
            '{8'h00, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0},
            '{8'hFF, 1'b1, 1'b1, 12'd2, 1'b1, 1'b0},
            '{8'h10, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0},
            '{8'h20, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0},
            '{8'h30, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0},
            '{8'h40, 1'b1, 1'b1, 12'd8, 1'b1, 1'b0},
            '{8'hAA, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0},
            '{8'hAA, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0},
            '{8'hAA, 1'b1, 1'b1, 12'd0, 1'b1, 1'b0},
            '{8'h01, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0},
            '{8'h01, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0},
            '{8'h02, 1'b1, 1'b0, 12'd0, 1'b0, 1'b0},
            '{8'h80, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0},
            '{8'hC3, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0},
            '{8'h3C, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0},
            '{8'h7E, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0},
            '{8'h81, 1'b1, 1'b0, 12'd0, 1'b0, 1'b0}
        };

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) begin
            typed_s = '{rows[i].bits, rows[i].low, rows[i].ovf};
            offer(rows[i].sym, rows[i].last, rows[i].typed, typed_s);
        end
        settle();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    thr = '0;
                end
                1: begin
                    thr = 12'd2048;
                end
                2: begin
                    thr = '1;
                end
                3: begin
                    thr = bse_pkg::THR_W'($urandom_range(0, 40));
                end
                default: begin
                    thr = bse_pkg::THR_W'($urandom_range(1, 30));
                end
            endcase
            set_threshold(thr);
            calm <= (p == 2);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                send_random_string();
            end
            if (p == 1) begin
                // every byte value once: the largest estimate
                foreach (perm[i]) begin
                    perm[i] = i;
                end
                for (int i = bse_pkg::NUM_BINS - 1; i > 0; i--) begin
                    j       = $urandom_range(0, i);
                    tmp     = perm[i];
                    perm[i] = perm[j];
                    perm[j] = tmp;
                end
                typed_s = '{default: '0};
                for (int i = 0; i < bse_pkg::NUM_BINS; i++) begin
                    offer(8'(perm[i]), (i == bse_pkg::NUM_BINS - 1), 1'b0, typed_s);
                end
            end else if (p == 3) begin
                // final byte lands past the length limit
                send_string($urandom_range(bse_pkg::MAX_LEN + 1, bse_pkg::MAX_LEN + 14),
                            8'hFF);
            end
            settle();
        end

        s_valid <= 1'b0;
        while (expected_scores.size() != 0) begin
            @(posedge aclk);
        end
        repeat (200) @(posedge aclk);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
